FILE: hw/rtl/image_compare_tolerance_defines.svh
// assertion macros for the image compare tolerance rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef IMAGE_COMPARE_TOLERANCE_DEFINES_SVH
`define IMAGE_COMPARE_TOLERANCE_DEFINES_SVH

// property checked on every clock edge outside reset
`define ICT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define ICT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/ict_pkg.sv
// types and constants for the image compare tolerance block
// used by ict_pixel_eval, ict_frame_track and image_compare_tolerance
package ict_pkg;

  // channel layout of an rgba pixel
  localparam int CH_W   = 8;
  localparam int NUM_CH = 4;
  localparam int PIX_W  = CH_W * NUM_CH;

  // field widths
  localparam int TOL_W      = 8;
  localparam int COUNT_W    = 25;
  localparam int CFG_SIZE_W = 13;
  localparam int COORD_W    = 12;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // diff image colors
  localparam logic [PIX_W-1:0] MAGENTA_PIX  = 32'hFFFF00FF;
  localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0]  GREY_BIAS    = 8'd24;

  // grey / 9 as a reciprocal multiply, exact for sums up to 765
  localparam int GREY_SUM_W = 10;
  localparam int GREY_MUL_W = 10;
  localparam logic [GREY_MUL_W-1:0] GREY_MUL = 10'd911;
  localparam int GREY_SHIFT = 13;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TOLERANCE     = 2'd0,
    REG_MAX_DIFFERENT = 2'd1,
    REG_FRAME_WIDTH   = 2'd2,
    REG_FRAME_HEIGHT  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] actual_pixel;
    logic [PIX_W-1:0] expected_pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   diff_pixel;
    logic               pixel_differs;
    logic               frame_done;
    logic               frame_match;
    logic [COUNT_W-1:0] differing_count;
    logic [TOL_W-1:0]   peak_delta;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
  } out_t;

  // per-pixel evaluation handed to the frame tracker
  typedef struct packed {
    logic [CH_W-1:0]  worst;
    logic             differs;
    logic [PIX_W-1:0] diff_pixel;
  } pix_eval_t;

  // frame report, fields zero unless done
  typedef struct packed {
    logic               done;
    logic               match;
    logic [COUNT_W-1:0] count;
    logic [TOL_W-1:0]   peak;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } frame_report_t;

endpackage

FILE: hw/rtl/ict_pixel_eval.sv
// per-pixel compare: worst channel delta, tolerance test and diff pixel
// depends on ict_pkg
module ict_pixel_eval (
  input  logic [ict_pkg::PIX_W-1:0] actual_pixel,
  input  logic [ict_pkg::PIX_W-1:0] expected_pixel,
  input  logic [ict_pkg::TOL_W-1:0] tolerance,
  output ict_pkg::pix_eval_t        eval
);
  import ict_pkg::*;

  logic [NUM_CH-1:0][CH_W-1:0]      delta;
  logic [CH_W-1:0]                  worst;
  logic [GREY_SUM_W-1:0]            grey_sum;
  logic [GREY_SUM_W+GREY_MUL_W-1:0] grey_prod;
  logic [CH_W-1:0]                  grey_v;

  // absolute difference per channel
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (actual_pixel[CH_W*k +: CH_W] > expected_pixel[CH_W*k +: CH_W]) begin
        delta[k] = actual_pixel[CH_W*k +: CH_W] - expected_pixel[CH_W*k +: CH_W];
      end else begin
        delta[k] = expected_pixel[CH_W*k +: CH_W] - actual_pixel[CH_W*k +: CH_W];
      end
    end
  end

  // largest of the four deltas
  always_comb begin
    worst = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      if (delta[k] > worst) begin
        worst = delta[k];
      end
    end
  end

  // dimmed grey of the expected pixel: (r+g+b)/9 + bias
  assign grey_sum = GREY_SUM_W'(expected_pixel[CH_W*0 +: CH_W])
                  + GREY_SUM_W'(expected_pixel[CH_W*1 +: CH_W])
                  + GREY_SUM_W'(expected_pixel[CH_W*2 +: CH_W]);
  assign grey_prod = (GREY_SUM_W+GREY_MUL_W)'(grey_sum) * (GREY_SUM_W+GREY_MUL_W)'(GREY_MUL);
  assign grey_v    = CH_W'(grey_prod >> GREY_SHIFT) + GREY_BIAS;

  // result bundle
  always_comb begin
    eval.worst   = worst;
    eval.differs = (worst > tolerance);
    if (eval.differs) begin
      eval.diff_pixel = MAGENTA_PIX;
    end else begin
      eval.diff_pixel = {ALPHA_OPAQUE, grey_v, grey_v, grey_v};
    end
  end

endmodule

FILE: hw/rtl/ict_frame_track.sv
// frame position counters, differing count, peak delta and bounding box
// depends on ict_pkg and image_compare_tolerance_defines.svh
`include "image_compare_tolerance_defines.svh"

module ict_frame_track #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  ict_pkg::pix_eval_t             eval,
  input  logic [ict_pkg::CFG_SIZE_W-1:0] frame_width,
  input  logic [ict_pkg::CFG_SIZE_W-1:0] frame_height,
  input  logic [ict_pkg::COUNT_W-1:0]    max_different,
  output ict_pkg::frame_report_t         report
);
  import ict_pkg::*;

  localparam int CW   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WB   = $clog2(MAX_WIDTH + 1);
  localparam int HB   = $clog2(MAX_HEIGHT + 1);
  localparam int DB   = (WB > HB) ? WB : HB;
  localparam int SZ_W = (DB > CFG_SIZE_W) ? DB : CFG_SIZE_W;

  logic [CW-1:0]      col_r, col_nxt, left_r, left_nxt, right_r, right_nxt;
  logic [RW-1:0]      row_r, row_nxt, top_r, top_nxt, bottom_r, bottom_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [TOL_W-1:0]   peak_r, peak_nxt;
  logic               seen_r, seen_nxt;

  logic [SZ_W-1:0]    w_ext, h_ext, eff_w, eff_h;
  logic               row_end, done;
  logic [CW-1:0]      left_upd, right_upd;
  logic [RW-1:0]      top_upd, bottom_upd;
  logic [COUNT_W-1:0] count_upd;
  logic [TOL_W-1:0]   peak_upd;
  logic               seen_upd;

  // effective frame size: zero acts as one, clamp to the maximum
  assign w_ext = SZ_W'(frame_width);
  assign h_ext = SZ_W'(frame_height);
  assign eff_w = (w_ext == '0) ? SZ_W'(1) :
                 (w_ext > SZ_W'(MAX_WIDTH)) ? SZ_W'(MAX_WIDTH) : w_ext;
  assign eff_h = (h_ext == '0) ? SZ_W'(1) :
                 (h_ext > SZ_W'(MAX_HEIGHT)) ? SZ_W'(MAX_HEIGHT) : h_ext;

  // row and frame end, tolerant of a size change mid-frame
  assign row_end = (SZ_W'(col_r) + SZ_W'(1)) >= eff_w;
  assign done    = row_end && ((SZ_W'(row_r) + SZ_W'(1)) >= eff_h);

  // accumulators including the current pixel
  always_comb begin
    peak_upd   = (eval.worst > peak_r) ? eval.worst : peak_r;
    count_upd  = count_r;
    seen_upd   = seen_r;
    left_upd   = left_r;
    right_upd  = right_r;
    top_upd    = top_r;
    bottom_upd = bottom_r;
    if (eval.differs) begin
      if (count_r != COUNT_MAX) begin
        count_upd = count_r + COUNT_W'(1);
      end
      seen_upd = 1'b1;
      if (!seen_r) begin
        left_upd   = col_r;
        right_upd  = col_r;
        top_upd    = row_r;
        bottom_upd = row_r;
      end else begin
        if (col_r < left_r)   left_upd   = col_r;
        if (col_r > right_r)  right_upd  = col_r;
        if (row_r < top_r)    top_upd    = row_r;
        if (row_r > bottom_r) bottom_upd = row_r;
      end
    end
  end

  // frame report, only populated on the last pixel
  always_comb begin
    report      = '0;
    report.done = done;
    if (done) begin
      report.match = (count_upd <= max_different);
      report.count = count_upd;
      report.peak  = peak_upd;
      if (seen_upd) begin
        report.left   = COORD_W'(left_upd);
        report.top    = COORD_W'(top_upd);
        report.right  = COORD_W'(right_upd);
        report.bottom = COORD_W'(bottom_upd);
      end
    end
  end

  // next state on each pixel transfer
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    count_nxt  = count_r;
    peak_nxt   = peak_r;
    seen_nxt   = seen_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    if (advance) begin
      if (done) begin
        col_nxt    = '0;
        row_nxt    = '0;
        count_nxt  = '0;
        peak_nxt   = '0;
        seen_nxt   = 1'b0;
        left_nxt   = '0;
        right_nxt  = '0;
        top_nxt    = '0;
        bottom_nxt = '0;
      end else begin
        count_nxt  = count_upd;
        peak_nxt   = peak_upd;
        seen_nxt   = seen_upd;
        left_nxt   = left_upd;
        right_nxt  = right_upd;
        top_nxt    = top_upd;
        bottom_nxt = bottom_upd;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      count_r  <= '0;
      peak_r   <= '0;
      seen_r   <= 1'b0;
      left_r   <= '0;
      right_r  <= '0;
      top_r    <= '0;
      bottom_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      count_r  <= count_nxt;
      peak_r   <= peak_nxt;
      seen_r   <= seen_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
    end
  end

  // no differing pixel yet means an empty count
  `ICT_ASSERT(a_count_needs_seen, (!seen_r) |-> (count_r == '0), "count without a differing pixel")
  // the box stays ordered once a differing pixel was seen
  `ICT_ASSERT(a_box_ordered, seen_r |-> ((left_r <= right_r) && (top_r <= bottom_r)), "box out of order")
  // the last pixel of a frame leaves a cleared frame state
  `ICT_ASSERT(a_frame_clears, (advance && done) |=> ((col_r == '0) && (row_r == '0) && !seen_r && (peak_r == '0)), "frame state not cleared")

endmodule

FILE: hw/rtl/image_compare_tolerance.sv
// top level of the streaming rgba image comparator with tolerance
// depends on ict_pkg, ict_pixel_eval and ict_frame_track

// Compares an actual and an expected RGBA frame streamed in raster order, one pixel pair per
// transfer, and returns one diff-image pixel per pair with the per-pixel verdict; the frame's
// last pixel also carries the differing count, peak delta, bounding box and match verdict.
// Throughput is one pixel per clock cycle unless the result side stalls. An input transfer
// loads the pair into the input register; once the result register is free, the channel
// compare, grey multiply and frame accumulators evaluate in a single pass into the result
// register. The user must set frame size, tolerance and match limit through the configuration
// port while idle, unenforced by the block; MAX_WIDTH and MAX_HEIGHT bound the frame geometry.
module image_compare_tolerance #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ict_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ict_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [ict_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ict_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ict_pkg::*;

  logic [TOL_W-1:0]      tol_r, tol_nxt;
  logic [COUNT_W-1:0]    maxd_r, maxd_nxt;
  logic [CFG_SIZE_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;

  logic          in_valid_r, in_valid_nxt;
  in_t           in_data_r;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;
  logic          advance;
  pix_eval_t     eval;
  frame_report_t report;

  // configuration register writes
  always_comb begin
    tol_nxt  = tol_r;
    maxd_nxt = maxd_r;
    fw_nxt   = fw_r;
    fh_nxt   = fh_r;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_addr))
        REG_TOLERANCE:     tol_nxt  = cfg_wdata[TOL_W-1:0];
        REG_MAX_DIFFERENT: maxd_nxt = cfg_wdata[COUNT_W-1:0];
        REG_FRAME_WIDTH:   fw_nxt   = cfg_wdata[CFG_SIZE_W-1:0];
        REG_FRAME_HEIGHT:  fh_nxt   = cfg_wdata[CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= '0;
      maxd_r <= '0;
      fw_r   <= CFG_SIZE_W'(1);
      fh_r   <= CFG_SIZE_W'(1);
    end else begin
      tol_r  <= tol_nxt;
      maxd_r <= maxd_nxt;
      fw_r   <= fw_nxt;
      fh_r   <= fh_nxt;
    end
  end

  // pipeline handshake: the input stage moves on when the result register is free
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  ict_pixel_eval u_pixel_eval (
    .actual_pixel   (in_data_r.actual_pixel),
    .expected_pixel (in_data_r.expected_pixel),
    .tolerance      (tol_r),
    .eval           (eval)
  );

  ict_frame_track #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_frame_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .eval          (eval),
    .frame_width   (fw_r),
    .frame_height  (fh_r),
    .max_different (maxd_r),
    .report        (report)
  );

  // assemble the result item
  always_comb begin
    out_data_nxt.diff_pixel      = eval.diff_pixel;
    out_data_nxt.pixel_differs   = eval.differs;
    out_data_nxt.frame_done      = report.done;
    out_data_nxt.frame_match     = report.match;
    out_data_nxt.differing_count = report.count;
    out_data_nxt.peak_delta      = report.peak;
    out_data_nxt.box_left        = report.left;
    out_data_nxt.box_top         = report.top;
    out_data_nxt.box_right       = report.right;
    out_data_nxt.box_bottom      = report.bottom;
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: sim/tb_image_compare_tolerance.sv
// self-checking testbench for the streaming rgba image comparator
// depends on ict_pkg and image_compare_tolerance from the rtl
module tb_image_compare_tolerance;
  timeunit 1ns;
  timeprecision 1ps;
  import ict_pkg::*;

  localparam int MAX_DIM      = 4096;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PRINT_CAP    = 30;

  typedef enum logic [1:0] {ROW_SETUP, ROW_PIXEL, ROW_KNOWN} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [TOL_W-1:0]   tol;
    logic [COUNT_W-1:0] limit;
    logic [12:0]        wid;
    logic [12:0]        hgt;
    in_t                px;
    out_t               want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // shadow copy of the configuration
  logic [TOL_W-1:0]   tol_cfg    = '0;
  logic [COUNT_W-1:0] limit_cfg  = '0;
  logic [12:0]        width_cfg  = 13'd1;
  logic [12:0]        height_cfg = 13'd1;

  // shadow copy of the frame accumulators
  int                 col_pos    = 0;
  int                 row_pos    = 0;
  logic [COUNT_W-1:0] diff_tally = '0;
  int                 peak_seen  = 0;
  bit                 any_seen   = 1'b0;
  int                 left_edge  = 0;
  int                 top_edge   = 0;
  int                 right_edge = 0;
  int                 bottom_edge = 0;

  out_t      pending_results[$];
  stim_row_t stim_rows[$];

  int  cycle_count   = 0;
  int  error_count   = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  frames_seen   = 0;
  int  differs_seen  = 0;
  int  phase_count   = 0;
  bit  steady        = 1'b0;
  bit  hold_req      = 1'b0;

  image_compare_tolerance dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // expected diff pixel and frame report for one pixel pair
  function automatic out_t predict_diff(in_t px);
    out_t r;
    int   ew, eh, worst, a, e, d, k, grey;
    bit   differs, row_end, done;
    ew = (width_cfg == 0) ? 1 : ((width_cfg > MAX_DIM) ? MAX_DIM : int'(width_cfg));
    eh = (height_cfg == 0) ? 1 : ((height_cfg > MAX_DIM) ? MAX_DIM : int'(height_cfg));
    worst = 0;
    for (k = 0; k < 4; k++) begin
      a = int'(px.actual_pixel[8*k +: 8]);
      e = int'(px.expected_pixel[8*k +: 8]);
      d = (a > e) ? a - e : e - a;
      if (d > worst) worst = d;
    end
    if (worst > peak_seen) peak_seen = worst;
    differs = worst > int'(tol_cfg);
    r = '0;
    if (differs) begin
      r.diff_pixel = {8'hFF, 8'hFF, 8'h00, 8'hFF};
    end else begin
      grey = (int'(px.expected_pixel[7:0]) + int'(px.expected_pixel[15:8]) +
              int'(px.expected_pixel[23:16])) / 3 / 3 + 24;
      r.diff_pixel = {8'hFF, grey[7:0], grey[7:0], grey[7:0]};
    end
    r.pixel_differs = differs;
    // bounding box and saturating count
    if (differs) begin
      if (~&diff_tally) diff_tally = diff_tally + COUNT_W'(1);
      if (!any_seen) begin
        left_edge   = col_pos;
        right_edge  = col_pos;
        top_edge    = row_pos;
        bottom_edge = row_pos;
        any_seen    = 1'b1;
      end else begin
        if (col_pos < left_edge)   left_edge   = col_pos;
        if (col_pos > right_edge)  right_edge  = col_pos;
        if (row_pos < top_edge)    top_edge    = row_pos;
        if (row_pos > bottom_edge) bottom_edge = row_pos;
      end
    end
    // raster position, a shrunk size ends the row or frame early
    row_end = col_pos + 1 >= ew;
    done    = row_end && (row_pos + 1 >= eh);
    r.frame_done = done;
    if (done) begin
      r.frame_match     = diff_tally <= limit_cfg;
      r.differing_count = diff_tally;
      r.peak_delta      = peak_seen[7:0];
      if (any_seen) begin
        r.box_left   = left_edge[COORD_W-1:0];
        r.box_top    = top_edge[COORD_W-1:0];
        r.box_right  = right_edge[COORD_W-1:0];
        r.box_bottom = bottom_edge[COORD_W-1:0];
      end
      col_pos = 0;
      row_pos = 0;
      diff_tally = '0;
      peak_seen = 0;
      any_seen = 1'b0;
      left_edge = 0;
      top_edge = 0;
      right_edge = 0;
      bottom_edge = 0;
    end else if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  // idle length: mostly short, a few long, none in steady stretches
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // copy of a pixel with each channel moved around the tolerance
  function automatic logic [31:0] nudge_pixel(logic [31:0] base, int tol);
    logic [31:0] px;
    int          k, r, d, v;
    for (k = 0; k < 4; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) d = $urandom_range(0, tol);
      else if (r < 85) d = tol + int'($urandom_range(0, 2)) - 1;
      else d = $urandom_range(0, 255);
      if (d < 0) d = 0;
      v = int'(base[8*k +: 8]);
      v = ($urandom_range(0, 1) != 0) ? v + d : v - d;
      if (v > 255 || v < 0) v = (v > 255) ? int'(base[8*k +: 8]) - d : int'(base[8*k +: 8]) + d;
      if (v > 255) v = 255;
      if (v < 0) v = 0;
      px[8*k +: 8] = v[7:0];
    end
    return px;
  endfunction

  function automatic stim_row_t setup_row(logic [TOL_W-1:0] tol, logic [COUNT_W-1:0] limit,
                                          logic [12:0] wid, logic [12:0] hgt);
    stim_row_t s;
    s = '{kind: ROW_SETUP, default: '0};
    s.kind  = ROW_SETUP;
    s.tol   = tol;
    s.limit = limit;
    s.wid   = wid;
    s.hgt   = hgt;
    return s;
  endfunction

  function automatic stim_row_t pixel_row(logic [31:0] act, logic [31:0] ref_px);
    stim_row_t s;
    s = '{kind: ROW_PIXEL, default: '0};
    s.kind = ROW_PIXEL;
    s.px.actual_pixel   = act;
    s.px.expected_pixel = ref_px;
    return s;
  endfunction

  // one-pixel frame at the origin, report read straight off the inputs
  function automatic stim_row_t known_row(logic [31:0] act, logic [31:0] ref_px,
                                          logic [31:0] diff, bit differs, bit match,
                                          logic [COUNT_W-1:0] count, logic [7:0] peak);
    stim_row_t s;
    s = pixel_row(act, ref_px);
    s.kind = ROW_KNOWN;
    s.want = '0;
    s.want.diff_pixel      = diff;
    s.want.pixel_differs   = differs;
    s.want.frame_done      = 1'b1;
    s.want.frame_match     = match;
    s.want.differing_count = count;
    s.want.peak_delta      = peak;
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PRINT_CAP)
      $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  // compare one result transfer with the oldest expectation
  task automatic check_result(out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending", got.diff_pixel, '0);
    end else begin
      want = pending_results.pop_front();
      check_field("diff_pixel", got.diff_pixel, want.diff_pixel);
      check_field("pixel_differs", 32'(got.pixel_differs), 32'(want.pixel_differs));
      check_field("frame_done", 32'(got.frame_done), 32'(want.frame_done));
      check_field("frame_match", 32'(got.frame_match), 32'(want.frame_match));
      check_field("differing_count", 32'(got.differing_count), 32'(want.differing_count));
      check_field("peak_delta", 32'(got.peak_delta), 32'(want.peak_delta));
      check_field("box_left", 32'(got.box_left), 32'(want.box_left));
      check_field("box_top", 32'(got.box_top), 32'(want.box_top));
      check_field("box_right", 32'(got.box_right), 32'(want.box_right));
      check_field("box_bottom", 32'(got.box_bottom), 32'(want.box_bottom));
    end
    results_seen++;
    if (got.frame_done) frames_seen++;
    if (got.pixel_differs) differs_seen++;
  endtask

  // result side monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  // result side ready with random stalls and one long hold-off
  initial begin
    int stall, n;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = gap_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // offer one pixel pair and queue its expectation on transfer
  task automatic send_pixel(in_t px, bit known, out_t want);
    int   gap;
    out_t predicted;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    predicted = predict_diff(px);
    pending_results.push_back(known ? want : predicted);
    items_sent++;
  endtask

  // drain, then write all four registers
  task automatic apply_settings(logic [TOL_W-1:0] tol, logic [COUNT_W-1:0] limit,
                                logic [12:0] wid, logic [12:0] hgt);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_TOLERANCE;
    cfg_wdata <= CFG_DATA_W'(tol);
    @(posedge clk);
    cfg_addr  <= REG_MAX_DIFFERENT;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_addr  <= REG_FRAME_WIDTH;
    cfg_wdata <= CFG_DATA_W'(wid);
    @(posedge clk);
    cfg_addr  <= REG_FRAME_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(hgt);
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_cfg    = tol;
    limit_cfg  = limit;
    width_cfg  = wid;
    height_cfg = hgt;
    phase_count++;
  endtask

  // stop on a hung handshake
  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // main stimulus
  initial begin
    stim_row_t s;
    in_t       px;
    int        ew, eh, n, k, r, random_done;
    logic [TOL_W-1:0]   tol;
    logic [COUNT_W-1:0] limit;
    logic [12:0]        wid, hgt;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_TOLERANCE;
    cfg_wdata = '0;

    // reset defaults: one-pixel frames, zero tolerance, zero allowed
    stim_rows.push_back(known_row(32'h0000_0000, 32'h0000_0000, 32'hFF18_1818,
                                  1'b0, 1'b1, 25'd0, 8'h00));
    stim_rows.push_back(known_row(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_00FF,
                                  1'b1, 1'b0, 25'd1, 8'hFF));
    stim_rows.push_back(known_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF6D_6D6D,
                                  1'b0, 1'b1, 25'd0, 8'h00));
    stim_rows.push_back(known_row(32'h0100_0000, 32'h0000_0000, 32'hFFFF_00FF,
                                  1'b1, 1'b0, 25'd1, 8'h01));
    // widest tolerance, zero size acts as one pixel
    stim_rows.push_back(setup_row(8'hFF, '1, 13'd0, 13'd0));
    stim_rows.push_back(known_row(32'hFFFF_FFFF, 32'h0000_0000, 32'hFF18_1818,
                                  1'b0, 1'b1, 25'd0, 8'hFF));
    // 3x2 frame with differences in every color channel
    stim_rows.push_back(setup_row(8'd0, 25'd1, 13'd3, 13'd2));
    stim_rows.push_back(pixel_row(32'h0000_0000, 32'h0000_0000));
    stim_rows.push_back(pixel_row(32'h0000_00FF, 32'h0000_0000));
    stim_rows.push_back(pixel_row(32'h1234_5678, 32'h1234_5678));
    stim_rows.push_back(pixel_row(32'h00FF_0000, 32'h0080_0000));
    stim_rows.push_back(pixel_row(32'h8080_8080, 32'h8080_8080));
    stim_rows.push_back(pixel_row(32'h0000_FF00, 32'h0000_FE00));
    // oversize frame, cut short by a narrower width
    stim_rows.push_back(setup_row(8'd16, 25'd2, 13'h1FFF, 13'h1FFF));
    stim_rows.push_back(pixel_row(32'hAA55_AA55, 32'hAA55_AA55));
    stim_rows.push_back(pixel_row(32'h0000_0011, 32'h0000_0000));
    stim_rows.push_back(pixel_row(32'h0000_0010, 32'h0000_0000));
    stim_rows.push_back(setup_row(8'd16, 25'd2, 13'd2, 13'd1));
    stim_rows.push_back(pixel_row(32'hFFFF_FFFF, 32'h7F7F_7F7F));
    // height lowered partway down a frame
    stim_rows.push_back(setup_row(8'd0, 25'd0, 13'd2, 13'd3));
    stim_rows.push_back(pixel_row(32'hDEAD_BEEF, 32'hDEAD_BEEF));
    stim_rows.push_back(pixel_row(32'h0102_0304, 32'h0102_0305));
    stim_rows.push_back(pixel_row(32'hCAFE_F00D, 32'hCAFE_F00D));
    stim_rows.push_back(setup_row(8'd0, 25'd0, 13'd2, 13'd1));
    stim_rows.push_back(pixel_row(32'h0000_0000, 32'hFFFF_FFFF));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (stim_rows[i]) begin
      s = stim_rows[i];
      if (s.kind == ROW_SETUP) apply_settings(s.tol, s.limit, s.wid, s.hgt);
      else send_pixel(s.px, s.kind == ROW_KNOWN, s.want);
    end

    // random phases, each drained before its settings change
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      tol = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : (r < 7) ? 8'($urandom_range(0, 40))
          : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 9);
      limit = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? 25'd16777216
            : 25'($urandom_range(0, 12));
      r = $urandom_range(0, 19);
      wid = (r == 0) ? 13'd0 : (r == 1) ? 13'($urandom_range(4096, 8191))
          : 13'($urandom_range(1, 8));
      r = $urandom_range(0, 19);
      hgt = (r == 0) ? 13'd0 : (r == 1) ? 13'd4096 : 13'($urandom_range(1, 6));
      apply_settings(tol, limit, wid, hgt);

      ew = (wid == 0) ? 1 : ((wid > MAX_DIM) ? MAX_DIM : int'(wid));
      eh = (hgt == 0) ? 1 : ((hgt > MAX_DIM) ? MAX_DIM : int'(hgt));
      // whole frames mostly, partial frames leave work for the next size
      if (ew * eh > 64) n = $urandom_range(5, 40);
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, ew * eh * 2);
      else n = ew * eh * $urandom_range(1, 4);

      steady = ($urandom_range(0, 4) == 0);
      if (phase_count == 9) begin
        steady   = 1'b1;
        hold_req = 1'b1;
        if (n < 30) n = 30;
      end

      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        px.expected_pixel = $urandom();
        if (r < 75) px.actual_pixel = nudge_pixel(px.expected_pixel, int'(tol));
        else if (r < 85) px.actual_pixel = px.expected_pixel;
        else px.actual_pixel = $urandom();
        send_pixel(px, 1'b0, '0);
        random_done++;
      end
      steady = 1'b0;
    end

    // drain and let any stray result show up
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d pixel transfers over %0d settings phases, %0d frame reports",
             items_sent, phase_count, frames_seen);
    $display("%0d result transfers checked, %0d differing pixels, %0d mismatches",
             results_seen, differs_seen, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: image_compare_tolerance.f
+incdir+hw/rtl
hw/rtl/ict_pkg.sv
hw/rtl/ict_pixel_eval.sv
hw/rtl/ict_frame_track.sv
hw/rtl/image_compare_tolerance.sv
sim/tb_image_compare_tolerance.sv
